@@ design/trd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the TGA RLE stream decoder: header layout,
// status codes and the command that passes from the parser to the expander.
// ----------------------------------------------------------------------------
package trd_pkg;

    // Largest image side that is accepted is 2^DIM_BITS - 1.
    localparam int DIM_BITS  = 16;
    // Width and height fields of the TGA header.
    localparam int HDR_DIM_W = 16;
    localparam int PIX_CNT_W = 2 * HDR_DIM_W;
    localparam logic [HDR_DIM_W:0] DIM_MAX = (HDR_DIM_W + 1)'((1 << DIM_BITS) - 1);

    // Packet repeat count, 1 to 128.
    localparam int RUN_W = 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    // Header byte positions.
    localparam int HDR_IDX_W = 5;
    localparam logic [HDR_IDX_W-1:0] HDR_ID_LEN   = 5'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_CMAP     = 5'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE     = 5'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [HDR_IDX_W-1:0] HDR_HGT_LO   = 5'd14;
    localparam logic [HDR_IDX_W-1:0] HDR_HGT_HI   = 5'd15;
    localparam logic [HDR_IDX_W-1:0] HDR_BPP      = 5'd16;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST     = 5'd17;

    localparam logic [7:0] TYPE_RAW = 8'h02;
    localparam logic [7:0] TYPE_RLE = 8'h0A;
    localparam logic [7:0] BPP_24   = 8'd24;
    localparam logic [7:0] BPP_32   = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_CMAP = 3'd1,
        ST_TYPE = 3'd2,
        ST_BPP  = 3'd3,
        ST_SIZE = 3'd4
    } status_t;

    // One pixel repeated count times, or a header error when status is not ok.
    typedef struct packed {
        logic [31:0]      pixel;
        logic [RUN_W-1:0] count;
        logic             ends_image;
        logic             transparent;
        status_t          status;
    } cmd_t;

endpackage
`default_nettype wire

@@ design/trd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trd_front
// Byte parser: collects and checks the header, skips the ID field, decodes
// packet headers, assembles pixels and sends one command per raw pixel or run.
// ----------------------------------------------------------------------------
module trd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_en,
    input  wire logic [7:0]    data_byte,
    input  wire logic          first_byte,
    output logic               cmd_push,
    output trd_pkg::cmd_t      cmd
);
    import trd_pkg::*;

    typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_ID, PH_DATA, PH_STOP} phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [7:0]             id_rem_reg, id_rem_next;
    logic [HDR_DIM_W-1:0]   width_reg, width_next;
    logic [HDR_DIM_W-1:0]   height_reg, height_next;
    logic [7:0]             cmap_reg, cmap_next;
    logic [7:0]             type_reg, type_next;
    logic [7:0]             bpp_reg, bpp_next;
    logic                   is_rle_reg, is_rle_next;
    logic                   is_32_reg, is_32_next;
    logic [RUN_W-1:0]       pkt_rem_reg, pkt_rem_next;
    logic                   pkt_run_reg, pkt_run_next;
    logic [1:0]             pix_idx_reg, pix_idx_next;
    logic [23:0]            gather_reg, gather_next;
    logic [PIX_CNT_W-1:0]   left_reg, left_next;
    logic                   transp_reg, transp_next;

    logic                   pix_done;
    logic [7:0]             alpha;
    logic [7:0]             red;
    logic [31:0]            pixel;
    logic [RUN_W-1:0]       want;
    logic [RUN_W-1:0]       clipped;
    logic [PIX_CNT_W-1:0]   left_after;
    logic                   size_bad;

    always_comb
    begin
        pix_done   = (pix_idx_reg == (is_32_reg ? 2'd3 : 2'd2));
        alpha      = is_32_reg ? data_byte : ALPHA_OPAQUE;
        red        = is_32_reg ? gather_reg[23:16] : data_byte;
        pixel      = {alpha, gather_reg[7:0], gather_reg[15:8], red};
        if (!is_rle_reg || !pkt_run_reg)
        begin
            want = RUN_W'(1);
        end
        else
        begin
            want = pkt_rem_reg;
        end
        if (left_reg < PIX_CNT_W'(want))
        begin
            clipped = left_reg[RUN_W-1:0];
        end
        else
        begin
            clipped = want;
        end
        left_after = left_reg - PIX_CNT_W'(clipped);
        size_bad   = (width_reg == '0) || (height_reg == '0)
                     || ({1'b0, width_reg} > DIM_MAX) || ({1'b0, height_reg} > DIM_MAX);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        id_rem_next  = id_rem_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        cmap_next    = cmap_reg;
        type_next    = type_reg;
        bpp_next     = bpp_reg;
        is_rle_next  = is_rle_reg;
        is_32_next   = is_32_reg;
        pkt_rem_next = pkt_rem_reg;
        pkt_run_next = pkt_run_reg;
        pix_idx_next = pix_idx_reg;
        gather_next  = gather_reg;
        left_next    = left_reg;
        transp_next  = transp_reg;
        cmd_push     = 1'b0;
        cmd.pixel       = '0;
        cmd.count       = RUN_W'(1);
        cmd.ends_image  = 1'b0;
        cmd.transparent = transp_reg;
        cmd.status      = ST_OK;

        if (byte_en)
        begin
            if (first_byte)
            begin
                // A new file always restarts, and this byte is the ID length.
                phase_next   = PH_HEADER;
                hdr_idx_next = HDR_IDX_W'(1);
                id_rem_next  = data_byte;
                width_next   = '0;
                height_next  = '0;
                cmap_next    = '0;
                type_next    = '0;
                bpp_next     = '0;
                transp_next  = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
                        unique case (hdr_idx_reg)
                            HDR_ID_LEN:   id_rem_next = data_byte;
                            HDR_CMAP:     cmap_next = data_byte;
                            HDR_TYPE:     type_next = data_byte;
                            HDR_WIDTH_LO: width_next[7:0] = data_byte;
                            HDR_WIDTH_HI: width_next[15:8] = data_byte;
                            HDR_HGT_LO:   height_next[7:0] = data_byte;
                            HDR_HGT_HI:   height_next[15:8] = data_byte;
                            HDR_BPP:      bpp_next = data_byte;
                            default:      ;
                        endcase
                        if (hdr_idx_reg == HDR_LAST)
                        begin
                            hdr_idx_next = '0;
                            priority if (cmap_reg != '0)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = ST_CMAP;
                            end
                            else if (type_reg != TYPE_RAW && type_reg != TYPE_RLE)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = ST_TYPE;
                            end
                            else if (bpp_reg != BPP_24 && bpp_reg != BPP_32)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = ST_BPP;
                            end
                            else if (size_bad)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = ST_SIZE;
                            end
                            if (cmd_push)
                            begin
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                is_rle_next  = (type_reg == TYPE_RLE);
                                is_32_next   = (bpp_reg == BPP_32);
                                left_next    = PIX_CNT_W'(width_reg) * PIX_CNT_W'(height_reg);
                                pkt_rem_next = '0;
                                pkt_run_next = 1'b0;
                                pix_idx_next = '0;
                                phase_next   = (id_rem_reg != '0) ? PH_ID : PH_DATA;
                            end
                        end
                    end
                    PH_ID:
                    begin
                        id_rem_next = id_rem_reg - 8'd1;
                        if (id_rem_reg == 8'd1)
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (is_rle_reg && pkt_rem_reg == '0)
                        begin
                            pkt_rem_next = RUN_W'({1'b0, data_byte[6:0]}) + RUN_W'(1);
                            pkt_run_next = data_byte[7];
                        end
                        else if (!pix_done)
                        begin
                            pix_idx_next = pix_idx_reg + 2'd1;
                            unique case (pix_idx_reg)
                                2'd0:    gather_next[7:0]   = data_byte;
                                2'd1:    gather_next[15:8]  = data_byte;
                                2'd2:    gather_next[23:16] = data_byte;
                                default: ;
                            endcase
                        end
                        else
                        begin
                            pix_idx_next    = '0;
                            transp_next     = transp_reg | (alpha != ALPHA_OPAQUE);
                            if (is_rle_reg)
                            begin
                                pkt_rem_next = pkt_run_reg ? '0 : pkt_rem_reg - RUN_W'(1);
                            end
                            left_next       = left_after;
                            cmd_push        = 1'b1;
                            cmd.pixel       = pixel;
                            cmd.count       = clipped;
                            cmd.ends_image  = (left_after == '0);
                            cmd.transparent = transp_next;
                            if (left_after == '0)
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hdr_idx_reg <= '0;
            id_rem_reg  <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            cmap_reg    <= '0;
            type_reg    <= '0;
            bpp_reg     <= '0;
            is_rle_reg  <= 1'b0;
            is_32_reg   <= 1'b0;
            pkt_rem_reg <= '0;
            pkt_run_reg <= 1'b0;
            pix_idx_reg <= '0;
            gather_reg  <= '0;
            left_reg    <= '0;
            transp_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            id_rem_reg  <= id_rem_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            cmap_reg    <= cmap_next;
            type_reg    <= type_next;
            bpp_reg     <= bpp_next;
            is_rle_reg  <= is_rle_next;
            is_32_reg   <= is_32_next;
            pkt_rem_reg <= pkt_rem_next;
            pkt_run_reg <= pkt_run_next;
            pix_idx_reg <= pix_idx_next;
            gather_reg  <= gather_next;
            left_reg    <= left_next;
            transp_reg  <= transp_next;
        end
    end

endmodule
`default_nettype wire

@@ design/trd_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trd_cmd_fifo
// Short command queue between the parser and the pixel expander.
// ----------------------------------------------------------------------------
module trd_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire trd_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output trd_pkg::cmd_t      pop_data,
    output logic               empty
);
    import trd_pkg::*;

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    always_comb
    begin
        full        = (fill_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
        empty       = (fill_reg == '0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        pop_data    = entry_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (FIFO_AW + 1)'(do_push) - (FIFO_AW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ design/trd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trd_back
// Pixel expander: takes one command at a time and sends its pixels up to two
// to a result through a registered output stage.
// ----------------------------------------------------------------------------
module trd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fifo_empty,
    input  wire trd_pkg::cmd_t                 fifo_data,
    output logic                               fifo_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [trd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output logic [2:0]                         m_tuser
);
    import trd_pkg::*;

    logic             cur_valid_reg, cur_valid_next;
    cmd_t             cur_reg;
    logic [RUN_W-1:0] rem_reg, rem_next;
    logic [RUN_W-1:0] rem_after;
    logic             two;
    logic             slot_free;
    logic             produce;

    logic             out_valid_reg, out_valid_next;
    logic [31:0]      first_reg;
    logic [31:0]      second_reg;
    logic             second_valid_reg;
    logic             last_reg;
    logic             done_reg;
    logic             transp_reg;
    status_t          status_reg;

    always_comb
    begin
        slot_free = !out_valid_reg || m_tready;
        fifo_pop  = !cur_valid_reg && !fifo_empty;
        produce   = cur_valid_reg && slot_free;
        two       = (rem_reg > RUN_W'(1));
        rem_after = rem_reg - (two ? RUN_W'(2) : RUN_W'(1));

        cur_valid_next = cur_valid_reg;
        rem_next       = rem_reg;
        if (fifo_pop)
        begin
            cur_valid_next = 1'b1;
            rem_next       = fifo_data.count;
        end
        else if (produce)
        begin
            rem_next = rem_after;
            if (rem_after == '0)
            begin
                cur_valid_next = 1'b0;
            end
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            cur_reg <= fifo_data;
        end
        if (produce)
        begin
            first_reg        <= cur_reg.pixel;
            second_reg       <= two ? cur_reg.pixel : '0;
            second_valid_reg <= two;
            last_reg         <= (rem_after == '0);
            done_reg         <= cur_reg.ends_image && (rem_after == '0);
            transp_reg       <= cur_reg.transparent;
            status_reg       <= cur_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, transp_reg, done_reg, second_valid_reg, second_reg, first_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

endmodule
`default_nettype wire

@@ design/tga_rle_stream_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_stream_decoder
// Path: a byte that completes a pixel passes the command queue, the command
// register and the output stage. Input: one byte per cycle while the
// four-entry command queue has room. Output: the expander loads one command
// at a time and sends its pixels up to two to a result, which sets the
// sustained rate for runs. Reset (asynchronous, active low) empties the queue
// and output stage and returns the parser to waiting for a first byte.
// ----------------------------------------------------------------------------
module tga_rle_stream_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [trd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tuser,   // [0] first_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [trd_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] pixel_first,
                                                          // [63:32] pixel_second,
                                                          // [64] second_valid,
                                                          // [65] image_done,
                                                          // [66] transparent,
                                                          // [71:67] zero
    output logic                               m_tlast,   // run_last
    output logic [2:0]                         m_tuser    // [2:0] status
);
    import trd_pkg::*;

    // The parser sees every transfer; it may push one command per byte.
    logic  byte_en;
    logic  cmd_push;
    cmd_t  cmd;
    logic  fifo_full;
    logic  fifo_empty;
    logic  fifo_pop;
    cmd_t  fifo_data;

    // Input is held off only while the command queue is full, so the parser
    // never has to drop a command.
    assign s_tready = !fifo_full;
    assign byte_en  = s_tvalid && s_tready;

    trd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .cmd_push   (cmd_push),
        .cmd        (cmd)
    );

    trd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_data),
        .empty     (fifo_empty)
    );

    // The expander turns each command into results of up to two pixels.
    trd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (fifo_data),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

`ifndef ASSERT_OFF
    // The parser must never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd_push && fifo_full))
        else $error("command pushed into a full queue");

    // A header error is a single result with no second pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tlast && !m_tdata[64]))
        else $error("error status result is not a lone final result");

    // The end of the image is always the end of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65]) |-> m_tlast)
        else $error("image end flagged without run end");
`endif

endmodule
`default_nettype wire
